// File: rtl/core/e2r_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler angle to
// rotation matrix block. No dependencies; used by e2r_sincos and the top level.
package e2r_pkg;

    localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
    localparam logic [32:0]        HALF_PI_Q32 = 33'd6746518852;

    // Taylor terms after the first one, for both sine and cosine.
    localparam int N_TERMS = 8;

    // Stages in the sine/cosine unit: angle scale, square, three per term, fold.
    localparam int SINCOS_LAT = 3 * N_TERMS + 3;
    // Stages in the matrix part: two products with rounding, sums, final rounding.
    localparam int MATRIX_LAT = 6;

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } quad_t;

    // Running state of one sine/cosine series that travels down the stages.
    typedef struct packed {
        logic signed [32:0] ss;
        logic signed [32:0] cc;
        logic [31:0]        x2;
        quad_t              quad;
    } series_t;

    function automatic logic [30:0] q30_abs(input logic signed [31:0] a);
        logic [31:0] m;
        m = a[31] ? 32'(-a) : 32'(a);
        return m[30:0];
    endfunction

    // Rounds a Q60 magnitude to Q30, half away from zero, then applies the sign.
    function automatic logic signed [31:0] q30_round(input logic [61:0] m, input logic neg);
        logic [62:0] sum;
        logic [31:0] p;
        sum = 63'(m) + 63'(33'd536870912);
        p = sum[61:30];
        return neg ? 32'(-p) : p;
    endfunction

    function automatic logic signed [31:0] q30_clamp(input logic signed [32:0] v);
        logic signed [32:0] r;
        if (v < 33'sd0) begin
            r = 33'sd0;
        end else if (v > Q30_ONE) begin
            r = Q30_ONE;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

// File: rtl/core/e2r_sincos.sv
// Pipelined sine and cosine of one binary angle, Q30 results.
// Depends on e2r_pkg for the series state type and fixed-point helpers.
module e2r_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [31:0]    sin_q,
    output logic signed [31:0]    cos_q
);

    localparam int NT = e2r_pkg::N_TERMS;

    logic [31:0] phase;
    logic [62:0] xprod;
    logic [30:0] x_reg;
    e2r_pkg::quad_t quad1_reg;
    logic [61:0] sq;

    logic [31:0]      ts_reg [0:NT];
    logic [31:0]      tc_reg [0:NT];
    e2r_pkg::series_t acc_reg [0:NT];

    logic signed [31:0] sin_reg, cos_reg;
    logic signed [31:0] sc_s, sc_c;

    assign phase = 32'(angle) << (32 - ANGLE_BITS);
    assign xprod = 63'(phase[29:0]) * 63'(e2r_pkg::HALF_PI_Q32);
    assign sq    = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= xprod[62:32];
            quad1_reg <= e2r_pkg::quad_t'(phase[31:30]);
            ts_reg[0]       <= 32'(x_reg);
            tc_reg[0]       <= e2r_pkg::Q30_ONE[31:0];
            acc_reg[0].ss   <= 33'(x_reg);
            acc_reg[0].cc   <= e2r_pkg::Q30_ONE;
            acc_reg[0].x2   <= sq[61:30];
            acc_reg[0].quad <= quad1_reg;
        end
    end

    // Each term is t * x^2 in Q30, then an exact floor division by a constant
    // done as a reciprocal multiply followed by a single correction step.
    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam logic [40:0] KS = 41'((2 * j + 2) * (2 * j + 3));
        localparam logic [40:0] KC = 41'((2 * j + 1) * (2 * j + 2));
        localparam logic [31:0] MS = 32'((64'd1 << 32) / KS);
        localparam logic [31:0] MC = 32'((64'd1 << 32) / KC);
        localparam bit SUBTRACT = ((j % 2) == 0);

        logic [63:0] prs_reg, prc_reg;
        e2r_pkg::series_t acca_reg, accb_reg;
        logic [31:0] ps_reg, pc_reg;
        logic [63:0] pms_reg, pmc_reg;
        logic [31:0] ps_next, pc_next;
        logic [31:0] q0s, q0c, qs, qc;
        logic [40:0] rs, rc;
        e2r_pkg::series_t acc_next;

        assign ps_next = prs_reg[61:30];
        assign pc_next = prc_reg[61:30];

        always_comb begin
            q0s = pms_reg[63:32];
            q0c = pmc_reg[63:32];
            rs  = 41'(ps_reg) - 41'(q0s) * KS;
            rc  = 41'(pc_reg) - 41'(q0c) * KC;
            qs  = (rs >= KS) ? q0s + 32'd1 : q0s;
            qc  = (rc >= KC) ? q0c + 32'd1 : q0c;
            acc_next = accb_reg;
            if (SUBTRACT) begin
                acc_next.ss = accb_reg.ss - 33'(qs);
                acc_next.cc = accb_reg.cc - 33'(qc);
            end else begin
                acc_next.ss = accb_reg.ss + 33'(qs);
                acc_next.cc = accb_reg.cc + 33'(qc);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                prs_reg  <= 64'(ts_reg[j]) * 64'(acc_reg[j].x2);
                prc_reg  <= 64'(tc_reg[j]) * 64'(acc_reg[j].x2);
                acca_reg <= acc_reg[j];
                ps_reg   <= ps_next;
                pc_reg   <= pc_next;
                pms_reg  <= 64'(ps_next) * 64'(MS);
                pmc_reg  <= 64'(pc_next) * 64'(MC);
                accb_reg <= acca_reg;
                ts_reg[j+1]  <= qs;
                tc_reg[j+1]  <= qc;
                acc_reg[j+1] <= acc_next;
            end
        end
    end

    always_comb begin
        sc_s = e2r_pkg::q30_clamp(acc_reg[NT].ss);
        sc_c = e2r_pkg::q30_clamp(acc_reg[NT].cc);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            case (acc_reg[NT].quad)
                e2r_pkg::QUAD_FIRST: begin
                    sin_reg <= sc_s;
                    cos_reg <= sc_c;
                end
                e2r_pkg::QUAD_SECOND: begin
                    sin_reg <= sc_c;
                    cos_reg <= -sc_s;
                end
                e2r_pkg::QUAD_THIRD: begin
                    sin_reg <= -sc_s;
                    cos_reg <= -sc_c;
                end
                default: begin
                    sin_reg <= -sc_c;
                    cos_reg <= sc_s;
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// File: rtl/core/euler_to_rotation_matrix.sv
// Top level: yaw, pitch and roll binary angles in, 3x3 rotation matrix out.
// Depends on e2r_pkg and e2r_sincos.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     yaw, pitch, roll angles
//   m_        out        m_valid / m_ready     forward, side, up rows (Q2.F)
//   cfg_      in         cfg_wr_en (no wait)   side_row_is_right
//
// One item per cycle while the skid stage is empty; items pass through the
// sine/cosine series pipeline, the matrix products and the output register.
// Reset clears the pipeline, output and skid valid bits and side register.
// The whole pipeline stalls only when the skid stage is full; a stalled
// output item sits in the output register while one more item is caught.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ANGLE_BITS-1:0]          s_yaw_angle,
    input  logic [ANGLE_BITS-1:0]          s_pitch_angle,
    input  logic [ANGLE_BITS-1:0]          s_roll_angle,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_forward_z,
    output logic signed [OUT_FRAC_BITS+1:0] m_side_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_side_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_side_z,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_x,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_y,
    output logic signed [OUT_FRAC_BITS+1:0] m_up_z
);

    localparam int OW    = OUT_FRAC_BITS + 2;
    localparam int SHIFT = 30 - OUT_FRAC_BITS;
    localparam int LAT   = e2r_pkg::SINCOS_LAT + e2r_pkg::MATRIX_LAT;
    localparam logic [33:0] RND   = (34'd1 << SHIFT) >> 1;
    localparam logic [33:0] LIMIT = 34'd1 << OUT_FRAC_BITS;
    localparam logic signed [OW-1:0] POS_LIM = OW'(LIMIT);
    localparam logic signed [OW-1:0] NEG_LIM = -POS_LIM;

    // First-level product slots.
    localparam int P_SRSP = 0;
    localparam int P_CRSP = 1;
    localparam int P_CPCY = 2;
    localparam int P_CPSY = 3;
    localparam int P_CRSY = 4;
    localparam int P_CRCY = 5;
    localparam int P_SRCP = 6;
    localparam int P_SRSY = 7;
    localparam int P_SRCY = 8;
    localparam int P_CRCP = 9;
    // Second-level product slots.
    localparam int Q_SRSPCY = 0;
    localparam int Q_SRSPSY = 1;
    localparam int Q_CRSPCY = 2;
    localparam int Q_CRSPSY = 3;

    function automatic logic signed [OW-1:0] finish_q(input logic signed [32:0] v);
        logic [32:0] u;
        logic [33:0] sum;
        logic [33:0] sh;
        logic [OW-1:0] mag;
        u   = v[32] ? 33'(-v) : 33'(v);
        sum = 34'(u) + RND;
        sh  = sum >> SHIFT;
        mag = (sh > LIMIT) ? OW'(LIMIT) : OW'(sh);
        return v[32] ? OW'(-mag) : mag;
    endfunction

    logic en;
    logic side_reg;
    logic [LAT-1:0] vld_reg;
    logic pipe_out;

    logic signed [31:0] sy, cy, sp, cp, sr, cr;

    logic signed [31:0] a1 [10];
    logic signed [31:0] b1 [10];
    logic [61:0] m1_reg [10];
    logic        n1_reg [10];
    logic signed [31:0] sy1_reg, cy1_reg, sp1_reg;
    logic signed [31:0] r1_reg [10];
    logic signed [31:0] sy2_reg, cy2_reg, sp2_reg;
    logic signed [31:0] a2 [4];
    logic signed [31:0] b2 [4];
    logic [61:0] m2_reg [4];
    logic        n2_reg [4];
    logic signed [31:0] r1c_reg [10];
    logic signed [31:0] sp3_reg;
    logic signed [31:0] r2_reg [4];
    logic signed [31:0] r1d_reg [10];
    logic signed [31:0] sp4_reg;
    logic signed [32:0] e_next [9];
    logic signed [32:0] e_reg [9];
    logic signed [OW-1:0] res_reg [9];
    logic signed [OW-1:0] out_reg [9];
    logic signed [OW-1:0] skid_reg [9];
    logic out_valid_reg, skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign pipe_out = vld_reg[LAT-1] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            side_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_yaw_angle), .sin_q(sy), .cos_q(cy)
    );
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_pitch_angle), .sin_q(sp), .cos_q(cp)
    );
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .aclk(aclk), .en(en), .angle(s_roll_angle), .sin_q(sr), .cos_q(cr)
    );

    always_comb begin
        a1[P_SRSP] = sr;  b1[P_SRSP] = sp;
        a1[P_CRSP] = cr;  b1[P_CRSP] = sp;
        a1[P_CPCY] = cp;  b1[P_CPCY] = cy;
        a1[P_CPSY] = cp;  b1[P_CPSY] = sy;
        a1[P_CRSY] = cr;  b1[P_CRSY] = sy;
        a1[P_CRCY] = cr;  b1[P_CRCY] = cy;
        a1[P_SRCP] = sr;  b1[P_SRCP] = cp;
        a1[P_SRSY] = sr;  b1[P_SRSY] = sy;
        a1[P_SRCY] = sr;  b1[P_SRCY] = cy;
        a1[P_CRCP] = cr;  b1[P_CRCP] = cp;
        a2[Q_SRSPCY] = r1_reg[P_SRSP];  b2[Q_SRSPCY] = cy2_reg;
        a2[Q_SRSPSY] = r1_reg[P_SRSP];  b2[Q_SRSPSY] = sy2_reg;
        a2[Q_CRSPCY] = r1_reg[P_CRSP];  b2[Q_CRSPCY] = cy2_reg;
        a2[Q_CRSPSY] = r1_reg[P_CRSP];  b2[Q_CRSPSY] = sy2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 10; i++) begin
                m1_reg[i]  <= 62'(e2r_pkg::q30_abs(a1[i])) * 62'(e2r_pkg::q30_abs(b1[i]));
                n1_reg[i]  <= a1[i][31] ^ b1[i][31];
                r1_reg[i]  <= e2r_pkg::q30_round(m1_reg[i], n1_reg[i]);
                r1c_reg[i] <= r1_reg[i];
                r1d_reg[i] <= r1c_reg[i];
            end
            sy1_reg <= sy;
            cy1_reg <= cy;
            sp1_reg <= sp;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            sp2_reg <= sp1_reg;
            sp3_reg <= sp2_reg;
            sp4_reg <= sp3_reg;
            for (int i = 0; i < 4; i++) begin
                m2_reg[i] <= 62'(e2r_pkg::q30_abs(a2[i])) * 62'(e2r_pkg::q30_abs(b2[i]));
                n2_reg[i] <= a2[i][31] ^ b2[i][31];
                r2_reg[i] <= e2r_pkg::q30_round(m2_reg[i], n2_reg[i]);
            end
        end
    end

    always_comb begin
        logic signed [32:0] lx, ly, lz;
        lx = 33'(r2_reg[Q_SRSPCY]) - 33'(r1d_reg[P_CRSY]);
        ly = 33'(r2_reg[Q_SRSPSY]) + 33'(r1d_reg[P_CRCY]);
        lz = 33'(r1d_reg[P_SRCP]);
        e_next[0] = 33'(r1d_reg[P_CPCY]);
        e_next[1] = 33'(r1d_reg[P_CPSY]);
        e_next[2] = -33'(sp4_reg);
        e_next[3] = side_reg ? -lx : lx;
        e_next[4] = side_reg ? -ly : ly;
        e_next[5] = side_reg ? -lz : lz;
        e_next[6] = 33'(r2_reg[Q_CRSPCY]) + 33'(r1d_reg[P_SRSY]);
        e_next[7] = 33'(r2_reg[Q_CRSPSY]) - 33'(r1d_reg[P_SRCY]);
        e_next[8] = 33'(r1d_reg[P_CRCP]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                e_reg[i]   <= e_next[i];
                res_reg[i] <= finish_q(e_reg[i]);
            end
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || pipe_out;
            skid_valid_reg <= 1'b0;
        end else if (pipe_out) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        end else if (pipe_out) begin
            skid_reg <= res_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_forward_x = out_reg[0];
    assign m_forward_y = out_reg[1];
    assign m_forward_z = out_reg[2];
    assign m_side_x    = out_reg[3];
    assign m_side_y    = out_reg[4];
    assign m_side_z    = out_reg[5];
    assign m_up_x      = out_reg[6];
    assign m_up_y      = out_reg[7];
    assign m_up_z      = out_reg[8];

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg)
        else $error("stalled output item dropped");

    a_entry_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (m_up_z <= POS_LIM && m_up_z >= NEG_LIM
                           && m_side_x <= POS_LIM && m_side_x >= NEG_LIM))
        else $error("matrix entry outside unit range");

endmodule

// File: verif/tb_euler_to_rotation_matrix.sv
// Testbench for euler_to_rotation_matrix: drives angle items with random idling,
// predicts each rotation matrix and compares the result rows field by field.
// Depends only on the RTL (the top level, e2r_sincos and e2r_pkg).
module tb_euler_to_rotation_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [17:0] ent[9];
    } matrix_t;

    class matrix_board;
        matrix_t pending[$];
        int errors;
        bit side_right;

        function longint qmul(longint a, longint b);
            bit neg;
            longint unsigned ua, ub, p;
            neg = (a < 0) != (b < 0);
            ua = a < 0 ? -a : a;
            ub = b < 0 ? -b : b;
            p = (ua * ub + (64'd1 << 29)) >> 30;
            return neg ? -longint'(p) : longint'(p);
        endfunction

        function void sin_cos(logic [15:0] ang, output longint s, output longint c);
            logic [31:0] phase;
            longint unsigned r, x, x2, t;
            longint ss, cc;
            phase = {ang, 16'd0};
            r = phase[29:0];
            x = (r * 64'd6746518852) >> 32;
            x2 = (x * x) >> 30;
            ss = x;
            cc = 64'sd1 << 30;
            t = x;
            for (int n = 3; n <= 17; n += 2) begin
                t = ((t * x2) >> 30) / ((n - 1) * n);
                ss += ((n >> 1) & 1) ? -longint'(t) : longint'(t);
            end
            t = 64'd1 << 30;
            for (int n = 2; n <= 16; n += 2) begin
                t = ((t * x2) >> 30) / ((n - 1) * n);
                cc += ((n >> 1) & 1) ? -longint'(t) : longint'(t);
            end
            if (ss < 0) ss = 0;
            if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
            if (cc < 0) cc = 0;
            if (cc > (64'sd1 << 30)) cc = 64'sd1 << 30;
            case (phase[31:30])
                2'd0: begin s = ss; c = cc; end
                2'd1: begin s = cc; c = -ss; end
                2'd2: begin s = -ss; c = -cc; end
                default: begin s = -cc; c = ss; end
            endcase
        endfunction

        function logic signed [17:0] to_q16(longint v);
            longint unsigned u;
            longint r;
            u = v < 0 ? -v : v;
            u = (u + (64'd1 << 13)) >> 14;
            if (u > 65536) u = 65536;
            r = v < 0 ? -longint'(u) : longint'(u);
            return r[17:0];
        endfunction

        function void note_orientation(logic [15:0] yaw, logic [15:0] pitch,
                                       logic [15:0] roll);
            longint sy, cy, sp, cp, sr, cr, srsp, crsp, lx, ly, lz;
            matrix_t m;
            sin_cos(yaw, sy, cy);
            sin_cos(pitch, sp, cp);
            sin_cos(roll, sr, cr);
            srsp = qmul(sr, sp);
            crsp = qmul(cr, sp);
            lx = qmul(srsp, cy) - qmul(cr, sy);
            ly = qmul(srsp, sy) + qmul(cr, cy);
            lz = qmul(sr, cp);
            if (side_right) begin
                lx = -lx; ly = -ly; lz = -lz;
            end
            m.ent[0] = to_q16(qmul(cp, cy));
            m.ent[1] = to_q16(qmul(cp, sy));
            m.ent[2] = to_q16(-sp);
            m.ent[3] = to_q16(lx);
            m.ent[4] = to_q16(ly);
            m.ent[5] = to_q16(lz);
            m.ent[6] = to_q16(qmul(crsp, cy) + qmul(sr, sy));
            m.ent[7] = to_q16(qmul(crsp, sy) - qmul(sr, cy));
            m.ent[8] = to_q16(qmul(cr, cp));
            pending.push_back(m);
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void check_matrix(matrix_t got);
            matrix_t exp_m;
            if (pending.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            exp_m = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.ent[i] !== exp_m.ent[i])
                    report($sformatf("entry %0d got %0d expected %0d", i,
                                     got.ent[i], exp_m.ent[i]));
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0, cfg_wr_data = 0;
    logic s_valid = 0, m_ready = 0;
    logic s_ready, m_valid;
    logic [15:0] s_yaw_angle = 0, s_pitch_angle = 0, s_roll_angle = 0;
    logic signed [17:0] m_forward_x, m_forward_y, m_forward_z;
    logic signed [17:0] m_side_x, m_side_y, m_side_z, m_up_x, m_up_y, m_up_z;

    matrix_board board = new();
    int idle_pct = 22;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    euler_to_rotation_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_yaw_angle(s_yaw_angle), .s_pitch_angle(s_pitch_angle),
        .s_roll_angle(s_roll_angle),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_forward_x(m_forward_x), .m_forward_y(m_forward_y),
        .m_forward_z(m_forward_z), .m_side_x(m_side_x), .m_side_y(m_side_y),
        .m_side_z(m_side_z), .m_up_x(m_up_x), .m_up_y(m_up_y), .m_up_z(m_up_z)
    );

    // Result side: random stalls and checking at each accepted item.
    always @(posedge aclk) begin
        matrix_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ent = '{m_forward_x, m_forward_y, m_forward_z, m_side_x, m_side_y,
                        m_side_z, m_up_x, m_up_y, m_up_z};
            board.check_matrix(got);
        end
        m_ready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("euler_to_rotation_matrix test failed");
            $finish;
        end
    end

    // Valid stays high from one item to the next unless the sender idles.
    task send_orientation(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
        bit idle;
        idle = ($urandom_range(99) < idle_pct);
        if (idle) s_valid <= 0;
        while (idle) begin
            @(posedge aclk);
            idle = ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1;
        s_yaw_angle <= yaw;
        s_pitch_angle <= pitch;
        s_roll_angle <= roll;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_orientation(yaw, pitch, roll);
    endtask

    task drain;
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task write_side_mode(bit right);
        cfg_wr_en <= 1;
        cfg_wr_data <= right;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.side_right = right;
    endtask

    function logic [15:0] pick_angle();
        // Favor quadrant boundaries and their neighbors now and then.
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] corners[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                    16'hFFFF, 16'h0001, 16'h3FFF, 16'h2000};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        for (int i = 0; i < 8; i++)
            send_orientation(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
        send_orientation(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_orientation(16'h5555, 16'hAAAA, 16'h1234);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_side_mode(phase[0] ^ phase[1] ? 1'b1 : 1'b0);
            send_orientation(16'h0000, 16'h0000, 16'h0000);
            send_orientation(16'h4000, 16'hC000, 16'h8000);
            // The second phase's random items run with no idling at all.
            idle_pct = (phase == 1) ? 0 : 22;
            for (int n = 0; n < 225; n++) begin
                send_orientation(pick_angle(), pick_angle(), pick_angle());
                if (n == 100) begin
                    // Hold the sender until every pending matrix has come back.
                    s_valid <= 0;
                    while (board.pending.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end

        if (board.errors == 0)
            $display("euler_to_rotation_matrix test passed");
        else
            $display("euler_to_rotation_matrix test failed");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/e2r_pkg.sv
rtl/core/e2r_sincos.sv
rtl/core/euler_to_rotation_matrix.sv
verif/tb_euler_to_rotation_matrix.sv
